// File: hw/rtl/lztd_pkg.sv
// Shared constants and controller/datapath interface types for the LZSS token decompressor.
package lztd_pkg;

   localparam int HISTORY_DEPTH_DEF    = 4096;
   localparam int LENGTH_CODE_BITS_DEF = 4;

   localparam int BYTE_WIDTH    = 8;
   localparam int DIST_WIDTH    = 12;
   localparam int LEN_WIDTH     = 4;
   localparam int REMAIN_WIDTH  = 5;
   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 8;

   typedef struct packed {
      logic load;
      logic read;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic is_ref;
      logic last_byte;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/lztd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lztd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lztd_ctrl.sv
// Token sequencer: accepts a token, then steps read and write phases per byte (write only for a literal).
module lztd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lztd_pkg::status_type status,
   output lztd_pkg::cmd_type    cmd
);
   import lztd_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      READ,
      WRITE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.is_ref ? READ : WRITE;
            end
         end
         READ: begin
            cmd.read = 1'b1;
            state_in = WRITE;
         end
         WRITE: begin
            if (status.out_free) begin
               cmd.write = 1'b1;
               state_in  = status.last_byte ? IDLE : READ;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/lztd_datapath.sv
// Token registers, history addressing, byte counters and output register.
module lztd_datapath #(
   parameter int HISTORY_DEPTH    = lztd_pkg::HISTORY_DEPTH_DEF,
   parameter int LENGTH_CODE_BITS = lztd_pkg::LENGTH_CODE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lztd_pkg::cmd_type                  cmd,
   output lztd_pkg::status_type               status,
   input  logic                               tok_is_ref,
   input  logic [lztd_pkg::BYTE_WIDTH-1:0]    tok_literal,
   input  logic [lztd_pkg::DIST_WIDTH-1:0]    tok_dist_code,
   input  logic [lztd_pkg::LEN_WIDTH-1:0]     tok_len_code,
   input  logic                               tok_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lztd_pkg::BYTE_WIDTH-1:0]    rsp_byte,
   output logic                               rsp_token_done,
   output logic                               rsp_block_done
);
   import lztd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int DW = DIST_WIDTH + 1;
   localparam int PW = ((CW > DW) ? CW : DW) + 1;

   logic [BYTE_WIDTH-1:0]   lit_ff;
   logic [DW-1:0]           dist_ff;
   logic [REMAIN_WIDTH-1:0] remain_ff;
   logic                    is_ref_ff;
   logic                    last_ff;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    zero_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]   rsp_byte_ff;
   logic                    rsp_token_ff;
   logic                    rsp_block_ff;

   logic [LEN_WIDTH-1:0]    len_mask;
   logic [PW-1:0]           wp_ext, dist_ext, cnt_ext, pos_ext;
   logic [AW-1:0]           rd_addr;
   logic [BYTE_WIDTH-1:0]   ram_rdata;
   logic [BYTE_WIDTH-1:0]   cur_byte;
   logic                    last_byte;

   always_comb begin
      for (int i = 0; i < LEN_WIDTH; i++) begin
         len_mask[i] = (i < LENGTH_CODE_BITS);
      end
   end

   assign wp_ext   = PW'(wp_ff);
   assign dist_ext = PW'(dist_ff);
   assign cnt_ext  = PW'(cnt_ff);

   always_comb begin
      if (wp_ext >= dist_ext) begin
         pos_ext = wp_ext - dist_ext;
      end else begin
         pos_ext = wp_ext + PW'(HISTORY_DEPTH) - dist_ext;
      end
   end
   assign rd_addr = pos_ext[AW-1:0];

   assign last_byte = (remain_ff == REMAIN_WIDTH'(1));
   assign cur_byte  = is_ref_ff ? (zero_ff ? '0 : ram_rdata) : lit_ff;

   assign status.is_ref    = tok_is_ref;
   assign status.last_byte = last_byte;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   lztd_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wp_ff),
      .wr_data (cur_byte),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
         wp_in = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (last_byte && last_ff) begin
            cnt_in = '0;
         end else if (cnt_ff < CW'(HISTORY_DEPTH)) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lit_ff    <= tok_literal;
         dist_ff   <= DW'(tok_dist_code) + DW'(1);
         is_ref_ff <= tok_is_ref;
         last_ff   <= tok_last;
         if (tok_is_ref) begin
            remain_ff <= REMAIN_WIDTH'(tok_len_code & len_mask) + REMAIN_WIDTH'(2);
         end else begin
            remain_ff <= REMAIN_WIDTH'(1);
         end
      end else if (cmd.write) begin
         remain_ff <= remain_ff - REMAIN_WIDTH'(1);
      end
      if (cmd.read) begin
         zero_ff <= (dist_ext > cnt_ext);
      end
      if (cmd.write) begin
         rsp_byte_ff  <= cur_byte;
         rsp_token_ff <= last_byte;
         rsp_block_ff <= last_byte && last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte       = rsp_byte_ff;
   assign rsp_token_done = rsp_token_ff;
   assign rsp_block_done = rsp_block_ff;

endmodule

// File: hw/rtl/lzss_token_decompressor.sv
// LZSS token decompressor top: sequencer plus history datapath, one token at a time.
// Literal: accept, then write; the byte is valid from the output register after the write.
// Back-reference of n = 2..17 bytes: accept, then a history read and a write per byte;
// first byte valid after its read and write. A write waits while the output is stalled.
// Reset clears the sequencer, write position, block byte count and output valid;
// history contents are kept as is.
module lzss_token_decompressor #(
   parameter int HISTORY_DEPTH    = lztd_pkg::HISTORY_DEPTH_DEF,
   parameter int LENGTH_CODE_BITS = lztd_pkg::LENGTH_CODE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // literal_byte[7:0], distance_code[19:8], length_code[23:20]
   input  logic [lztd_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // is_reference
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_byte[7:0]
   output logic [lztd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // block_done
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import lztd_pkg::*;

   cmd_type    cmd;
   status_type status;

   lztd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lztd_datapath #(
      .HISTORY_DEPTH    (HISTORY_DEPTH),
      .LENGTH_CODE_BITS (LENGTH_CODE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .tok_is_ref     (req_tuser),
      .tok_literal    (req_tdata[7:0]),
      .tok_dist_code  (req_tdata[19:8]),
      .tok_len_code   (req_tdata[23:20]),
      .tok_last       (req_tlast),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_byte       (rsp_tdata),
      .rsp_token_done (rsp_tlast),
      .rsp_block_done (rsp_tuser)
   );

endmodule
